>>> rtl/gbl_pkg.sv
// Shared constants for the gap-buffer line editor: command codes and field widths.
// No dependencies; imported by the editor top level and its checker.
`default_nettype none

package gbl_pkg;

    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;

    // Slave tdata: func, char_in, position, zero fill to whole bytes
    localparam int IN_USED = FUNC_W + CHAR_W + POS_W;
    localparam int IN_W    = ((IN_USED + 7) / 8) * 8;
    localparam int IN_PAD  = IN_W - IN_USED;

    // Master tdata: char_out, text_length, cursor_pos, rejected, zero fill
    localparam int OUT_USED = CHAR_W + 2 * LEN_W + 1;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_W - OUT_USED;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FN_LEFT   = 3'd0;
    localparam func_t FN_RIGHT  = 3'd1;
    localparam func_t FN_BACK   = 3'd2;
    localparam func_t FN_INSERT = 3'd3;
    localparam func_t FN_READ   = 3'd4;

endpackage

`default_nettype wire

>>> rtl/gbl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; contents are undefined until written.
`default_nettype none

module gbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gap_buffer_line_editor.sv
// A command beat is taken only in IDLE, which issues the single text memory's read;
// EXEC then writes the entry back and loads the output register, waiting while the
// last result beat is still unaccepted, before IDLE takes the next command.
// Reset (rst_n low, asynchronous) empties the line and clears the handshake state;
// the text memory is not cleared, no entry is read before it is written.
// Top level of the gap-buffer line editor; uses gbl_pkg and gbl_ram.
`default_nettype none

module gap_buffer_line_editor #(
    parameter int DEPTH = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [gbl_pkg::IN_W-1:0]  s_axis_tdata,  // func, char_in, position
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [gbl_pkg::OUT_W-1:0] m_axis_tdata   // char_out, text_length,
                                                          // cursor_pos, rejected
);

    import gbl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > LEN_W) ? CW : LEN_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     right_reg, right_next;
    logic              wr_en_reg, wr_en_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              ins_reg, ins_next;
    logic [CHAR_W-1:0] char_reg;
    logic              rd_hit_reg, rd_hit_next;
    logic              rej_reg, rej_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [LEN_W-1:0]  out_cur_reg;
    logic              out_rej_reg;

    func_t             func;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
    logic [EW-1:0]     left_e, right_e, used_e, pos_e, depth_e;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rdata;
    logic              accept;
    logic              exec_fire;

    assign func     = s_axis_tdata[FUNC_W-1:0];
    assign char_in  = s_axis_tdata[FUNC_W +: CHAR_W];
    assign position = s_axis_tdata[FUNC_W + CHAR_W +: POS_W];

    assign left_e  = EW'(left_reg);
    assign right_e = EW'(right_reg);
    assign used_e  = left_e + right_e;
    assign pos_e   = EW'(position);
    assign depth_e = EW'(DEPTH);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    // Decode the command against the current counts; the memory read goes out now
    always_comb
    begin
        left_next    = left_reg;
        right_next   = right_reg;
        wr_en_next   = 1'b0;
        wr_addr_next = AW'(left_e);
        ins_next     = 1'b0;
        rd_hit_next  = 1'b0;
        rej_next     = 1'b0;
        rd_addr      = '0;
        unique case (func)
            FN_LEFT:
            begin
                if (left_e != '0)
                begin
                    rd_addr      = AW'(left_e - 1'b1);
                    wr_addr_next = AW'(depth_e - right_e - 1'b1);
                    wr_en_next   = 1'b1;
                    left_next    = left_reg - 1'b1;
                    right_next   = right_reg + 1'b1;
                end
            end
            FN_RIGHT:
            begin
                if (right_e != '0)
                begin
                    rd_addr      = AW'(depth_e - right_e);
                    wr_addr_next = AW'(left_e);
                    wr_en_next   = 1'b1;
                    left_next    = left_reg + 1'b1;
                    right_next   = right_reg - 1'b1;
                end
            end
            FN_BACK:
            begin
                if (left_e != '0)
                begin
                    left_next = left_reg - 1'b1;
                end
            end
            FN_INSERT:
            begin
                if (used_e < depth_e)
                begin
                    wr_en_next = 1'b1;
                    ins_next   = 1'b1;
                    left_next  = left_reg + 1'b1;
                end
                else
                begin
                    rej_next = 1'b1;
                end
            end
            FN_READ:
            begin
                if (pos_e < used_e)
                begin
                    rd_hit_next = 1'b1;
                    if (pos_e < left_e)
                    begin
                        rd_addr = AW'(pos_e);
                    end
                    else
                    begin
                        rd_addr = AW'(depth_e - right_e + pos_e - left_e);
                    end
                end
                else
                begin
                    rej_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = ST_EXEC;
        end
        else if (exec_fire)
        begin
            state_next = ST_IDLE;
        end
    end

    // Hold the result until the sink takes it; reload on write-back
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
                wr_en_reg <= wr_en_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_addr_reg <= wr_addr_next;
            ins_reg     <= ins_next;
            char_reg    <= char_in;
            rd_hit_reg  <= rd_hit_next;
            rej_reg     <= rej_next;
        end
        if (exec_fire)
        begin
            out_char_reg <= rd_hit_reg ? rdata : '0;
            out_len_reg  <= used_e[LEN_W-1:0];
            out_cur_reg  <= left_e[LEN_W-1:0];
            out_rej_reg  <= rej_reg;
        end
    end

    gbl_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (exec_fire && wr_en_reg),
        .waddr (wr_addr_reg),
        .wdata (ins_reg ? char_reg : rdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_rej_reg, out_cur_reg, out_len_reg,
                            out_char_reg};

endmodule

`default_nettype wire

>>> rtl/gbl_checker.sv
// Port-level checker for the gap-buffer line editor, bound to the top level.
// Uses gbl_pkg for the beat layout.
`default_nettype none

module gbl_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic [gbl_pkg::IN_W-1:0]  s_axis_tdata,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [gbl_pkg::OUT_W-1:0] m_axis_tdata
);

    import gbl_pkg::*;

    logic              in_beat;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  text_length;
    logic [LEN_W-1:0]  cursor_pos;
    logic              rejected;

    assign in_beat     = s_axis_tvalid && s_axis_tready;
    assign char_out    = m_axis_tdata[CHAR_W-1:0];
    assign text_length = m_axis_tdata[CHAR_W +: LEN_W];
    assign cursor_pos  = m_axis_tdata[CHAR_W + LEN_W +: LEN_W];
    assign rejected    = m_axis_tdata[CHAR_W + 2 * LEN_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("second command taken while one is in flight");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_beat, 2))
        else $error("result beat without a command two cycles earlier");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && rejected |-> char_out == '0)
        else $error("rejected command returned a character");

    a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && text_length[LEN_W-1] == 1'b0 |-> cursor_pos <= text_length)
        else $error("cursor beyond end of text");

endmodule

bind gap_buffer_line_editor gbl_checker u_gbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/tb_gap_buffer_line_editor.sv
// Self-checking bench for gap_buffer_line_editor: drives command beats, tracks the line
// and cursor in a scoreboard class, and checks every result beat field by field.
// Depends on gbl_pkg and the editor RTL only.

module tb_gap_buffer_line_editor;

    import gbl_pkg::*;

    localparam int DEPTH = 1024;
    localparam func_t FN_UNUSED_FIRST = FN_READ + 3'd1;
    localparam func_t FN_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [CHAR_W-1:0] char_out;
        logic [LEN_W-1:0]  text_length;
        logic [LEN_W-1:0]  cursor_pos;
        logic              rejected;
    } edit_result_t;

    class line_edit_tracker #(int SIZE = 1024);
        logic [CHAR_W-1:0] text_mem [SIZE];
        int                left_chars;
        int                right_chars;
        edit_result_t      pending_results [$];
        int                errors;

        function new();
            foreach (text_mem[i])
                text_mem[i] = '0;
            left_chars  = 0;
            right_chars = 0;
            errors      = 0;
        endfunction

        function int text_len();
            return left_chars + right_chars;
        endfunction

        // Apply one accepted command to the tracked line and queue its result.
        function void note_command(func_t fn, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos);
            edit_result_t r;
            int           used;
            used       = left_chars + right_chars;
            r.char_out = '0;
            r.rejected = 1'b0;
            case (fn)
                FN_LEFT:
                    if (left_chars > 0)
                    begin
                        text_mem[SIZE - right_chars - 1] = text_mem[left_chars - 1];
                        left_chars--;
                        right_chars++;
                    end
                FN_RIGHT:
                    if (right_chars > 0)
                    begin
                        text_mem[left_chars] = text_mem[SIZE - right_chars];
                        left_chars++;
                        right_chars--;
                    end
                FN_BACK:
                    if (left_chars > 0)
                        left_chars--;
                FN_INSERT:
                    if (used < SIZE)
                    begin
                        text_mem[left_chars] = ch;
                        left_chars++;
                    end
                    else
                        r.rejected = 1'b1;
                FN_READ:
                    if (int'(pos) < used)
                    begin
                        if (int'(pos) < left_chars)
                            r.char_out = text_mem[pos];
                        else
                            r.char_out = text_mem[SIZE - right_chars + (int'(pos) - left_chars)];
                    end
                    else
                        r.rejected = 1'b1;
                default:
                    ;
            endcase
            r.text_length = LEN_W'(left_chars + right_chars);
            r.cursor_pos  = LEN_W'(left_chars);
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] beat);
            edit_result_t want;
            logic [CHAR_W-1:0] got_char;
            logic [LEN_W-1:0]  got_len;
            logic [LEN_W-1:0]  got_cur;
            logic              got_rej;
            got_char = beat[CHAR_W-1:0];
            got_len  = beat[CHAR_W +: LEN_W];
            got_cur  = beat[CHAR_W + LEN_W +: LEN_W];
            got_rej  = beat[CHAR_W + 2 * LEN_W];
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat %h with no command outstanding", beat));
                return;
            end
            want = pending_results.pop_front();
            if (got_char !== want.char_out)
                report($sformatf("char_out %h, want %h", got_char, want.char_out));
            if (got_len !== want.text_length)
                report($sformatf("text_length %0d, want %0d", got_len, want.text_length));
            if (got_cur !== want.cursor_pos)
                report($sformatf("cursor_pos %0d, want %0d", got_cur, want.cursor_pos));
            if (got_rej !== want.rejected)
                report($sformatf("rejected %b, want %b", got_rej, want.rejected));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // func, char_in, position
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // char_out, text_length, cursor_pos, rejected
    bit                calm;

    line_edit_tracker #(DEPTH) line;

    gap_buffer_line_editor #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check at the rising edge, pick the next tready at the falling edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                line.check_result(m_axis_tdata);
            @(negedge clk);
            m_axis_tready = calm ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    task send_command(func_t fn, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos);
        @(negedge clk);
        if (!calm)
            while ($urandom_range(99) < 32)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{IN_PAD{1'b0}}, pos, ch, fn};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        line.note_command(fn, ch, pos);
    endtask

    // Hold the command side idle until every queued result has come back or its wait limit is reached.
    task drain_results();
        int cycles;
        cycles = 0;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (line.pending_results.size() != 0 && cycles < 5000)
        begin
            @(posedge clk);
            cycles++;
        end
    endtask

    // Weights are percentages; whatever is left over goes to unused codes.
    task random_command(int w_left, int w_right, int w_back, int w_ins, int w_read);
        int                pick;
        int                len;
        logic [POS_W-1:0]  pos;
        func_t             fn;
        pick = $urandom_range(99);
        len  = line.text_len();
        pos  = POS_W'($urandom_range(1023));
        if (len > 0 && $urandom_range(1))
            pos = POS_W'($urandom_range(len - 1));
        if (pick < w_left)
            fn = FN_LEFT;
        else if (pick < w_left + w_right)
            fn = FN_RIGHT;
        else if (pick < w_left + w_right + w_back)
            fn = FN_BACK;
        else if (pick < w_left + w_right + w_back + w_ins)
            fn = FN_INSERT;
        else if (pick < w_left + w_right + w_back + w_ins + w_read)
            fn = FN_READ;
        else
            fn = func_t'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST));
        send_command(fn, CHAR_W'($urandom_range(255)), pos);
    endtask

    initial
    begin
        line          = new();
        rst_n         = 1'b0;
        calm          = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Edges of an empty line, then unused codes.
        send_command(FN_LEFT, 8'h00, 10'd0);
        send_command(FN_RIGHT, 8'h00, 10'd0);
        send_command(FN_BACK, 8'h00, 10'd0);
        send_command(FN_READ, 8'h00, 10'd0);
        send_command(FN_UNUSED_FIRST, 8'hFF, 10'h3FF);
        send_command(FN_UNUSED_FIRST + 3'd1, 8'h5A, 10'h155);
        send_command(FN_UNUSED_LAST, 8'hA5, 10'h2AA);
        // Build a short line and read it across the gap.
        send_command(FN_INSERT, 8'h00, 10'h3FF);
        send_command(FN_INSERT, 8'hFF, 10'h000);
        send_command(FN_INSERT, "P", 10'd0);
        send_command(FN_LEFT, 8'h00, 10'd0);
        send_command(FN_LEFT, 8'h00, 10'd0);
        send_command(FN_INSERT, "L", 10'd0);
        send_command(FN_READ, 8'h00, 10'd0);
        send_command(FN_READ, 8'h00, 10'd1);
        send_command(FN_READ, 8'h00, 10'd2);
        send_command(FN_READ, 8'h00, 10'd3);
        send_command(FN_READ, 8'hFF, 10'd4);
        send_command(FN_READ, 8'h00, 10'h3FF);
        send_command(FN_RIGHT, 8'h00, 10'd0);
        send_command(FN_RIGHT, 8'h00, 10'd0);
        send_command(FN_RIGHT, 8'h00, 10'd0);
        send_command(FN_BACK, 8'h00, 10'd0);
        send_command(FN_READ, 8'h00, 10'd2);

        repeat (200)
            random_command(18, 15, 12, 30, 20);
        drain_results();

        // Grow the line with no idling on either side.
        calm = 1'b1;
        repeat (150)
            random_command(4, 4, 2, 86, 3);
        calm = 1'b0;
        repeat (40)
            random_command(15, 15, 0, 35, 32);

        repeat (136)
            random_command(18, 12, 45, 8, 15);

        drain_results();
        repeat (10) @(posedge clk);
        if (line.pending_results.size() != 0)
            line.report($sformatf("%0d results never arrived", line.pending_results.size()));
        if (line.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/gbl_pkg.sv
rtl/gbl_ram.sv
rtl/gap_buffer_line_editor.sv
rtl/gbl_checker.sv
test/tb_gap_buffer_line_editor.sv
